>>> src/spq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// Shared constants and types of the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int MAX_RESULTS = 16;
    localparam int DATA_W      = 32;
    localparam int COUNT_W     = 5;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;

    typedef logic [1:0] t_status;

    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_FULL     = 2'd1;
    localparam t_status ST_EMPTY    = 2'd2;
    localparam t_status ST_BADCOUNT = 2'd3;

    localparam logic CMD_INSERT  = 1'b0;
    localparam logic CMD_EXTRACT = 1'b1;

    // register index of order_descending
    localparam logic REG_ORDER = 1'b0;

endpackage

>>> src/spq_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_in_if / spq_out_if
// Valid/ready channels carrying the command word and the result word.
// ----------------------------------------------------------------------------
interface spq_in_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   command;
    logic signed [spq_pkg::DATA_W-1:0]      value;
    logic        [spq_pkg::COUNT_W-1:0]     count;

    modport source (output valid, command, value, count, input ready);
    modport sink   (input valid, command, value, count, output ready);
endinterface

interface spq_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [spq_pkg::DATA_W-1:0]      value_res;
    spq_pkg::t_status                       status;
    logic                                   last;

    modport source (output valid, value_res, status, last, input ready);
    modport sink   (input valid, value_res, status, last, output ready);
endinterface

>>> src/spq_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_store
// Entry memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module spq_store #(
    parameter int DEPTH = spq_pkg::QUEUE_DEPTH,
    parameter int AW    = 4
) (
    input  logic                              i_clk,
    input  logic                              i_we,
    input  logic [AW-1:0]                     i_waddr,
    input  logic signed [spq_pkg::DATA_W-1:0] i_wdata,
    input  logic                              i_re,
    input  logic [AW-1:0]                     i_raddr,
    output logic signed [spq_pkg::DATA_W-1:0] o_rdata
);

    logic signed [spq_pkg::DATA_W-1:0] r_mem [DEPTH];
    logic signed [spq_pkg::DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/spq_cmp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_cmp
// Shared order compare: high when entry a must sit behind value b.
// ----------------------------------------------------------------------------
module spq_cmp (
    input  logic                              i_desc,
    input  logic signed [spq_pkg::DATA_W-1:0] i_a,
    input  logic signed [spq_pkg::DATA_W-1:0] i_b,
    output logic                              o_after
);

    assign o_after = i_desc ? (i_a < i_b) : (i_a > i_b);

endmodule

>>> src/spq_apb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_apb
// Configuration register file behind an APB-style port.
// ----------------------------------------------------------------------------
module spq_apb (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_psel,
    input  logic                               i_penable,
    input  logic                               i_pwrite,
    input  logic [spq_pkg::PADDR_W-1:0]        i_paddr,
    input  logic [spq_pkg::PDATA_W-1:0]        i_pwdata,
    output logic [spq_pkg::PDATA_W-1:0]        o_prdata,
    output logic                               o_pready,
    output logic                               o_order_desc
);

    logic r_order;
    logic n_order;
    logic w_sel;

    assign w_sel = (i_paddr[spq_pkg::PADDR_W-1] == spq_pkg::REG_ORDER);

    always_comb begin
        n_order = r_order;
        if (i_psel && i_penable && i_pwrite && w_sel) begin
            n_order = i_pwdata[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= 1'b0;
        end else begin
            r_order <= n_order;
        end
    end

    assign o_prdata     = w_sel ? {{(spq_pkg::PDATA_W-1){1'b0}}, r_order} : '0;
    assign o_pready     = 1'b1;
    assign o_order_desc = r_order;

endmodule

>>> src/sorted_priority_queue_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_core
// Bounded sorted priority queue: insert in order, extract runs from the front.
//
// Channel  Dir  Handshake      Word
// i_in     in   valid/ready    command, value, count
// o_out    out  valid/ready    value_res, status, last
// apb      in   psel/penable   order_descending at byte address 0
//
// Insert: the sequencer reads, compares and shifts the entries behind the new
// value, then writes it (one compare and one memory move per cycle through the
// single compare unit). Full and bad-count answers go straight to the answer.
// Extract: each value passes a read state and an output state, set by the one
// registered memory read port, and a closing empty word has its own state.
// Answers leave through an output register; a stalled output holds the
// sequencer. Reset is synchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
module sorted_priority_queue_core #(
    parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    spq_in_if.sink                       i_in,
    spq_out_if.source                    o_out,
    input  logic                         i_psel,
    input  logic                         i_penable,
    input  logic                         i_pwrite,
    input  logic [spq_pkg::PADDR_W-1:0]  i_paddr,
    input  logic [spq_pkg::PDATA_W-1:0]  i_pwdata,
    output logic [spq_pkg::PDATA_W-1:0]  o_prdata,
    output logic                         o_pready
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int DW = spq_pkg::DATA_W;
    localparam int KW = spq_pkg::COUNT_W;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_RD    = 8'b0000_0010,
        S_CMP   = 8'b0000_0100,
        S_PUT   = 8'b0000_1000,
        S_ANS   = 8'b0001_0000,
        S_XRD   = 8'b0010_0000,
        S_XOUT  = 8'b0100_0000,
        S_EMPTY = 8'b1000_0000
    } t_state;

    // logical position -> memory address for a ring walked in either direction
    function automatic logic [AW-1:0] f_phys(input logic [AW-1:0] h, input logic dir,
                                             input logic [CW-1:0] i);
        logic [CW:0] hx;
        logic [CW:0] ix;
        logic [CW:0] r;
        hx = (CW+1)'(h);
        ix = {1'b0, i};
        if (!dir) begin
            r = hx + ix;
            if (r >= (CW+1)'(QUEUE_DEPTH)) begin
                r = r - (CW+1)'(QUEUE_DEPTH);
            end
        end else begin
            if (ix > hx) begin
                r = hx + (CW+1)'(QUEUE_DEPTH) - ix;
            end else begin
                r = hx - ix;
            end
        end
        return r[AW-1:0];
    endfunction

    t_state                r_state, n_state;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic [AW-1:0]         r_head, n_head;
    logic                  r_dir, n_dir;
    logic                  r_sdesc, n_sdesc;
    logic [CW-1:0]         r_j, n_j;
    logic [KW-1:0]         r_rem, n_rem;
    logic signed [DW-1:0]  r_v, n_v;
    spq_pkg::t_status      r_status, n_status;
    logic                  r_ov, n_ov;
    logic signed [DW-1:0]  r_oval, n_oval;
    spq_pkg::t_status      r_ost, n_ost;
    logic                  r_olast, n_olast;

    logic                  w_order;
    logic                  w_accept;
    logic                  w_free;
    logic                  w_after;
    logic                  w_we;
    logic                  w_re;
    logic [CW-1:0]         w_wl;
    logic [CW-1:0]         w_rl;
    logic signed [DW-1:0]  w_wdata;
    logic signed [DW-1:0]  w_rdata;
    logic                  w_emit;
    logic signed [DW-1:0]  w_eval;
    spq_pkg::t_status      w_est;
    logic                  w_elast;

    spq_apb u_apb (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_psel       (i_psel),
        .i_penable    (i_penable),
        .i_pwrite     (i_pwrite),
        .i_paddr      (i_paddr),
        .i_pwdata     (i_pwdata),
        .o_prdata     (o_prdata),
        .o_pready     (o_pready),
        .o_order_desc (w_order)
    );

    spq_store #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (f_phys(r_head, r_dir, w_wl)),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (f_phys(r_head, r_dir, w_rl)),
        .o_rdata (w_rdata)
    );

    spq_cmp u_cmp (
        .i_desc  (r_sdesc),
        .i_a     (w_rdata),
        .i_b     (r_v),
        .o_after (w_after)
    );

    assign i_in.ready = (r_state == S_IDLE);
    assign w_accept   = i_in.valid && (r_state == S_IDLE);
    assign w_free     = !r_ov || o_out.ready;

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_head   = r_head;
        n_dir    = r_dir;
        n_sdesc  = r_sdesc;
        n_j      = r_j;
        n_rem    = r_rem;
        n_v      = r_v;
        n_status = r_status;
        w_we     = 1'b0;
        w_re     = 1'b0;
        w_wl     = r_j;
        w_rl     = r_j - CW'(1);
        w_wdata  = r_v;
        w_emit   = 1'b0;
        w_eval   = '0;
        w_est    = spq_pkg::ST_OK;
        w_elast  = 1'b1;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_v = i_in.value;
                    if (i_in.command == spq_pkg::CMD_INSERT) begin
                        if (r_cnt == CW'(QUEUE_DEPTH)) begin
                            n_status = spq_pkg::ST_FULL;
                            n_state  = S_ANS;
                        end else begin
                            // flip the walk direction to reverse the stored order
                            if (w_order != r_sdesc) begin
                                n_sdesc = w_order;
                                if (r_cnt != '0) begin
                                    n_head = f_phys(r_head, r_dir, r_cnt - CW'(1));
                                    n_dir  = !r_dir;
                                end
                            end
                            n_j      = r_cnt;
                            n_status = spq_pkg::ST_OK;
                            n_state  = S_RD;
                        end
                    end else begin
                        if (i_in.count == '0) begin
                            n_status = spq_pkg::ST_BADCOUNT;
                            n_state  = S_ANS;
                        end else begin
                            n_rem = (i_in.count > KW'(spq_pkg::MAX_RESULTS)) ?
                                    KW'(spq_pkg::MAX_RESULTS) : i_in.count;
                            n_state = (r_cnt == '0) ? S_EMPTY : S_XRD;
                        end
                    end
                end
            end
            S_RD: begin
                if (r_j == '0) begin
                    w_we    = 1'b1;
                    w_wl    = '0;
                    n_cnt   = r_cnt + CW'(1);
                    n_state = S_ANS;
                end else begin
                    w_re    = 1'b1;
                    w_rl    = r_j - CW'(1);
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                w_rl = r_j - CW'(2);
                w_re = (r_j >= CW'(2));
                w_we = 1'b1;
                w_wl = r_j;
                if (w_after) begin
                    w_wdata = w_rdata;
                    n_j     = r_j - CW'(1);
                    if (r_j == CW'(1)) begin
                        n_state = S_PUT;
                    end
                end else begin
                    n_cnt   = r_cnt + CW'(1);
                    n_state = S_ANS;
                end
            end
            S_PUT: begin
                w_we    = 1'b1;
                w_wl    = '0;
                n_cnt   = r_cnt + CW'(1);
                n_state = S_ANS;
            end
            S_ANS: begin
                if (w_free) begin
                    w_emit  = 1'b1;
                    w_est   = r_status;
                    n_state = S_IDLE;
                end
            end
            S_XRD: begin
                w_re    = 1'b1;
                w_rl    = '0;
                n_state = S_XOUT;
            end
            S_XOUT: begin
                if (w_free) begin
                    w_emit  = 1'b1;
                    w_eval  = w_rdata;
                    w_elast = (r_rem == KW'(1));
                    n_head  = f_phys(r_head, r_dir, CW'(1));
                    n_cnt   = r_cnt - CW'(1);
                    n_rem   = r_rem - KW'(1);
                    if (r_rem == KW'(1)) begin
                        n_state = S_IDLE;
                    end else if (r_cnt == CW'(1)) begin
                        n_state = S_EMPTY;
                    end else begin
                        n_state = S_XRD;
                    end
                end
            end
            S_EMPTY: begin
                if (w_free) begin
                    w_emit  = 1'b1;
                    w_est   = spq_pkg::ST_EMPTY;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_ov    = r_ov;
        n_oval  = r_oval;
        n_ost   = r_ost;
        n_olast = r_olast;
        if (w_emit) begin
            n_ov    = 1'b1;
            n_oval  = w_eval;
            n_ost   = w_est;
            n_olast = w_elast;
        end else if (o_out.ready) begin
            n_ov = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_head  <= '0;
            r_dir   <= 1'b0;
            r_sdesc <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_head  <= n_head;
            r_dir   <= n_dir;
            r_sdesc <= n_sdesc;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_j      <= n_j;
        r_rem    <= n_rem;
        r_v      <= n_v;
        r_status <= n_status;
        r_oval   <= n_oval;
        r_ost    <= n_ost;
        r_olast  <= n_olast;
    end

    assign o_out.valid     = r_ov;
    assign o_out.value_res = r_oval;
    assign o_out.status    = r_ost;
    assign o_out.last      = r_olast;

endmodule

>>> src/spq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks of the sorted priority queue, bound to the top level.
// ----------------------------------------------------------------------------
module spq_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              i_in_ready,
    input logic                              i_out_valid,
    input logic                              i_out_ready,
    input logic signed [spq_pkg::DATA_W-1:0] i_out_value_res,
    input spq_pkg::t_status                  i_out_status,
    input logic                              i_out_last
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result word dropped while stalled");

    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_status != spq_pkg::ST_OK) |->
            i_out_last && (i_out_value_res == '0))
        else $error("error status without last or with nonzero value");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("ready after accepting a command word");

    a_reset_out: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !i_out_valid)
        else $error("result word valid right after reset");

endmodule

bind sorted_priority_queue_core spq_checker u_spq_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_out_value_res (o_out.value_res),
    .i_out_status    (o_out.status),
    .i_out_last      (o_out.last)
);

>>> bench/tb_sorted_priority_queue_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_priority_queue_core
// Self-checking bench for the sorted priority queue. A directed table covers
// empty, bad and clamped counts, extreme values, equal values and a change of
// order with entries in the store. Random fill, drain and mixed sequences
// follow under both orders. A shadow queue predicts each result word that no
// typed table row fixes; both channels stall in random bursts.
// ----------------------------------------------------------------------------
module tb_sorted_priority_queue_core;

    localparam int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH;
    localparam int MAX_RESULTS = spq_pkg::MAX_RESULTS;
    localparam int DATA_W      = spq_pkg::DATA_W;
    localparam int COUNT_W     = spq_pkg::COUNT_W;
    localparam int PADDR_W     = spq_pkg::PADDR_W;
    localparam int PDATA_W     = spq_pkg::PDATA_W;

    localparam int CLK_HALF    = 10;
    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE      = 40;
    localparam int PHASE_WORDS = 100;
    localparam int NUM_PHASES  = 4;
    localparam int NUM_ROWS    = 20;

    typedef struct packed {
        logic signed [DATA_W-1:0] value_res;
        spq_pkg::t_status         status;
        logic                     last;
    } t_result;

    typedef struct {
        bit               typed;
        spq_pkg::t_status status;
    } t_word_note;

    typedef struct packed {
        logic                     wr_order;
        logic                     order_val;
        logic                     cmd;
        logic signed [DATA_W-1:0] val;
        logic [COUNT_W-1:0]       cnt;
        logic                     typed;
        spq_pkg::t_status         exp_status;
    } t_stim_row;

    logic                i_clk;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  o_prdata;
    logic                o_pready;

    spq_in_if  in_ch ();
    spq_out_if out_ch ();

    sorted_priority_queue_core DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (in_ch),
        .o_out     (out_ch),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready)
    );

    // shadow of the queue contents and order
    logic signed [DATA_W-1:0] shadow_store [QUEUE_DEPTH];
    int                       shadow_level;
    logic                     shadow_desc;

    t_result    awaited_results [$];
    t_word_note note_q [$];

    int  errors;
    int  sent_words;
    int  checked_results;
    int  seen_full;
    int  seen_empty;
    int  seen_bad;
    int  gen_level;
    bit  idle_on;
    int  stall_left;

    t_stim_row directed_rows [NUM_ROWS] = '{
        '{1'b1, 1'b0, spq_pkg::CMD_EXTRACT, 32'sd0,        5'd1,  1'b1, spq_pkg::ST_EMPTY},
        '{1'b0, 1'b0, spq_pkg::CMD_EXTRACT, 32'sd0,        5'd0,  1'b1, spq_pkg::ST_BADCOUNT},
        '{1'b0, 1'b0, spq_pkg::CMD_INSERT,  32'sh7FFFFFFF, 5'd0,  1'b1, spq_pkg::ST_OK},
        '{1'b0, 1'b0, spq_pkg::CMD_INSERT,  32'sh80000000, 5'd31, 1'b1, spq_pkg::ST_OK},
        '{1'b0, 1'b0, spq_pkg::CMD_INSERT,  32'sd0,        5'd0,  1'b1, spq_pkg::ST_OK},
        '{1'b0, 1'b0, spq_pkg::CMD_INSERT,  -32'sd1,       5'd0,  1'b1, spq_pkg::ST_OK},
        '{1'b0, 1'b0, spq_pkg::CMD_INSERT,  32'sd5,        5'd0,  1'b1, spq_pkg::ST_OK},
        '{1'b0, 1'b0, spq_pkg::CMD_INSERT,  32'sd5,        5'd0,  1'b1, spq_pkg::ST_OK},
        '{1'b0, 1'b0, spq_pkg::CMD_EXTRACT, 32'sd0,        5'd3,  1'b0, spq_pkg::ST_OK},
        '{1'b0, 1'b0, spq_pkg::CMD_INSERT,  32'sd12345,    5'd0,  1'b1, spq_pkg::ST_OK},
        '{1'b1, 1'b1, spq_pkg::CMD_EXTRACT, 32'sd0,        5'd1,  1'b0, spq_pkg::ST_OK},
        '{1'b0, 1'b0, spq_pkg::CMD_INSERT,  -32'sd7,       5'd0,  1'b1, spq_pkg::ST_OK},
        '{1'b0, 1'b0, spq_pkg::CMD_EXTRACT, 32'sd0,        5'd2,  1'b0, spq_pkg::ST_OK},
        '{1'b0, 1'b0, spq_pkg::CMD_EXTRACT, 32'sd0,        5'd31, 1'b0, spq_pkg::ST_OK},
        '{1'b0, 1'b0, spq_pkg::CMD_EXTRACT, 32'sd0,        5'd16, 1'b1, spq_pkg::ST_EMPTY},
        '{1'b0, 1'b0, spq_pkg::CMD_INSERT,  32'sh55555555, 5'd0,  1'b1, spq_pkg::ST_OK},
        '{1'b0, 1'b0, spq_pkg::CMD_INSERT,  32'shAAAAAAAA, 5'd0,  1'b1, spq_pkg::ST_OK},
        '{1'b0, 1'b0, spq_pkg::CMD_EXTRACT, 32'sd0,        5'd17, 1'b0, spq_pkg::ST_OK},
        '{1'b1, 1'b0, spq_pkg::CMD_INSERT,  32'sd1,        5'd0,  1'b1, spq_pkg::ST_OK},
        '{1'b0, 1'b0, spq_pkg::CMD_EXTRACT, 32'sd0,        5'd1,  1'b0, spq_pkg::ST_OK}
    };

    always begin
        i_clk = 1'b0;
        #CLK_HALF;
        i_clk = 1'b1;
        #CLK_HALF;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("%0t: timeout with %0d results outstanding", $time, awaited_results.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    // result channel back-pressure
    initial begin
        out_ch.ready = 1'b0;
        stall_left   = 0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 14) - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : track_queue
        t_word_note               note;
        t_result                  word_res [$];
        t_result                  got;
        t_result                  want;
        logic signed [DATA_W-1:0] key;
        logic signed [DATA_W-1:0] front;
        int                       i;
        int                       j;
        int                       k;
        int                       take;
        bit                       ran_dry;

        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                note = note_q.pop_front();
                word_res.delete();
                if (in_ch.command == spq_pkg::CMD_INSERT) begin
                    if (shadow_level < QUEUE_DEPTH) begin
                        shadow_store[shadow_level] = in_ch.value;
                        shadow_level++;
                        // resort the whole store under the current order
                        for (i = 1; i < shadow_level; i++) begin
                            key = shadow_store[i];
                            j   = i;
                            while (j > 0 && (shadow_desc ? (shadow_store[j-1] < key)
                                                         : (shadow_store[j-1] > key))) begin
                                shadow_store[j] = shadow_store[j-1];
                                j--;
                            end
                            shadow_store[j] = key;
                        end
                        word_res.push_back('{'0, spq_pkg::ST_OK, 1'b1});
                    end else begin
                        word_res.push_back('{'0, spq_pkg::ST_FULL, 1'b1});
                    end
                end else if (in_ch.count == 0) begin
                    word_res.push_back('{'0, spq_pkg::ST_BADCOUNT, 1'b1});
                end else begin
                    take    = (in_ch.count > MAX_RESULTS) ? MAX_RESULTS : int'(in_ch.count);
                    ran_dry = 1'b0;
                    for (k = 0; k < take && !ran_dry; k++) begin
                        if (shadow_level == 0) begin
                            word_res.push_back('{'0, spq_pkg::ST_EMPTY, 1'b1});
                            ran_dry = 1'b1;
                        end else begin
                            front = shadow_store[0];
                            for (i = 0; i + 1 < shadow_level; i++)
                                shadow_store[i] = shadow_store[i+1];
                            shadow_level--;
                            word_res.push_back('{front, spq_pkg::ST_OK, (k == take - 1)});
                        end
                    end
                end
                if (note.typed)
                    awaited_results.push_back('{'0, note.status, 1'b1});
                else
                    foreach (word_res[i])
                        awaited_results.push_back(word_res[i]);
            end

            if (out_ch.valid && out_ch.ready) begin
                got = '{out_ch.value_res, out_ch.status, out_ch.last};
                checked_results++;
                case (got.status)
                    spq_pkg::ST_FULL:     seen_full++;
                    spq_pkg::ST_EMPTY:    seen_empty++;
                    spq_pkg::ST_BADCOUNT: seen_bad++;
                    default: ;
                endcase
                if (awaited_results.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected word value_res %0d status %0d last %0b",
                             $time, got.value_res, got.status, got.last);
                end else begin
                    want = awaited_results.pop_front();
                    if (got.value_res !== want.value_res) begin
                        errors++;
                        $display("%0t: value_res expected %0d actual %0d",
                                 $time, want.value_res, got.value_res);
                    end
                    if (got.status !== want.status) begin
                        errors++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, got.status);
                    end
                    if (got.last !== want.last) begin
                        errors++;
                        $display("%0t: last expected %0b actual %0b",
                                 $time, want.last, got.last);
                    end
                end
            end
        end
    end

    function automatic logic signed [DATA_W-1:0] rand_value();
        int unsigned pick;
        pick = $urandom_range(0, 7);
        case (pick)
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            2, 3: return $signed($urandom_range(0, 16)) - 32'sd8;
            default: return $signed($urandom);
        endcase
    endfunction

    task automatic send_word(input logic cmd, input logic signed [DATA_W-1:0] val,
                             input logic [COUNT_W-1:0] cnt, input bit typed,
                             input spq_pkg::t_status exp_st);
        int take;
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge i_clk);
        end
        note_q.push_back('{typed, exp_st});
        in_ch.valid   <= 1'b1;
        in_ch.command <= cmd;
        in_ch.value   <= val;
        in_ch.count   <= cnt;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sent_words++;
        if (cmd == spq_pkg::CMD_INSERT) begin
            if (gen_level < QUEUE_DEPTH)
                gen_level++;
        end else if (cnt != 0) begin
            take      = (cnt > MAX_RESULTS) ? MAX_RESULTS : int'(cnt);
            gen_level = (take >= gen_level) ? 0 : gen_level - take;
        end
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (awaited_results.size() != 0 || note_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_order(input logic desc);
        drain_results();
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({spq_pkg::REG_ORDER, 2'b00});
        pwdata  <= PDATA_W'(desc);
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!o_pready) @(posedge i_clk);
        shadow_desc = desc;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!o_pready) @(posedge i_clk);
        if (o_prdata !== PDATA_W'(desc)) begin
            errors++;
            $display("%0t: order register expected %0h actual %0h",
                     $time, PDATA_W'(desc), o_prdata);
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial begin : stimulus
        int r;
        int ph;
        int kind;
        int target;
        int pick;
        logic [COUNT_W-1:0] cnt;

        i_rst_n       = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.command = spq_pkg::CMD_INSERT;
        in_ch.value   = '0;
        in_ch.count   = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        shadow_level  = 0;
        shadow_desc   = 1'b0;
        errors        = 0;
        sent_words    = 0;
        checked_results = 0;
        seen_full     = 0;
        seen_empty    = 0;
        seen_bad      = 0;
        gen_level     = 0;
        idle_on       = 1'b1;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (r = 0; r < NUM_ROWS; r++) begin
            if (directed_rows[r].wr_order)
                write_order(directed_rows[r].order_val);
            send_word(directed_rows[r].cmd, directed_rows[r].val, directed_rows[r].cnt,
                      directed_rows[r].typed, directed_rows[r].exp_status);
        end

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            write_order((ph % 2) == 0);
            idle_on = (ph != NUM_PHASES - 1);
            target  = sent_words + PHASE_WORDS;
            while (sent_words < target) begin
                kind = $urandom_range(0, 3);
                if (kind == 0) begin
                    // fill to capacity, with up to three inserts past it
                    repeat (QUEUE_DEPTH - gen_level + $urandom_range(0, 3))
                        send_word(spq_pkg::CMD_INSERT, rand_value(),
                                  COUNT_W'($urandom_range(0, 31)), 1'b0, spq_pkg::ST_OK);
                end else if (kind == 1) begin
                    // drain to empty, then overrun
                    while (gen_level > 0)
                        send_word(spq_pkg::CMD_EXTRACT, rand_value(),
                                  COUNT_W'($urandom_range(1, MAX_RESULTS)), 1'b0,
                                  spq_pkg::ST_OK);
                    send_word(spq_pkg::CMD_EXTRACT, rand_value(),
                              COUNT_W'($urandom_range(1, 31)), 1'b0, spq_pkg::ST_OK);
                end else begin
                    repeat ($urandom_range(3, 10)) begin
                        if ($urandom_range(0, 9) < 6) begin
                            send_word(spq_pkg::CMD_INSERT, rand_value(),
                                      COUNT_W'($urandom_range(0, 31)), 1'b0,
                                      spq_pkg::ST_OK);
                        end else begin
                            pick = $urandom_range(0, 9);
                            if (pick == 0)
                                cnt = '0;
                            else if (pick == 1)
                                cnt = COUNT_W'($urandom_range(MAX_RESULTS + 1, 31));
                            else
                                cnt = COUNT_W'($urandom_range(1, 4));
                            send_word(spq_pkg::CMD_EXTRACT, rand_value(), cnt, 1'b0,
                                      spq_pkg::ST_OK);
                        end
                    end
                end
            end
        end

        drain_results();
        $display("Covered %0d command words and %0d result words under both orders,",
                 sent_words, checked_results);
        $display("with %0d full, %0d empty and %0d bad-count answers.",
                 seen_full, seen_empty, seen_bad);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0t: %0d mismatches", $time, errors);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
